/* sv/assert_macros.svh */
// Assertion macros for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/tsfs_pkg.sv */
// ---------------------------------------------------------------------------
// tsfs_pkg
// Shared types and constants of the touch sample filter and scaler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsfs_pkg;

  localparam int unsigned RegW = 12;
  localparam int unsigned PosW = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned AdcBits = 12;
  // kept middle values per batch; a power of two so the mean is a shift
  localparam int unsigned KeepCount = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_X_CAL_LOW     = 3'd0,
    REG_X_CAL_HIGH    = 3'd1,
    REG_Y_CAL_LOW     = 3'd2,
    REG_Y_CAL_HIGH    = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_MIN_LEVEL     = 3'd6,
    REG_MAX_SPREAD    = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_PEN_UP   = 2'd1,
    ST_CAL_ZERO = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SORT,
    FSM_SUM,
    FSM_CHECK,
    FSM_DIV,
    FSM_OUT
  } fsm_e;

  // Control from the sequencer to the cell row
  typedef struct packed {
    logic load;    // insert one sample into the row
    logic clear;   // empty the row
    logic shift;   // shift the row toward the output end
  } row_ctrl_t;

endpackage

/* sv/tsfs_sort_cell.sv */
// ---------------------------------------------------------------------------
// tsfs_sort_cell
// One cell of an insertion sorting row: on a load it takes its left
// neighbor's value, the new sample or holds; on a shift it takes its right
// neighbor's value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsfs_sort_cell #(
  parameter int unsigned W = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsfs_pkg::row_ctrl_t ctrl_i,
  input  logic [W-1:0]        smp_i,
  input  logic                left_vld_i,
  input  logic [W-1:0]        left_val_i,
  input  logic                right_vld_i,
  input  logic [W-1:0]        right_val_i,
  output logic                vld_o,
  output logic [W-1:0]        val_o
);

  logic         vld_q, vld_d;
  logic [W-1:0] val_q, val_d;
  logic         cur_vld;

  assign cur_vld = vld_q && !ctrl_i.clear;

  always_comb begin
    vld_d = cur_vld;
    val_d = val_q;
    if (ctrl_i.load) begin
      if (left_vld_i && (smp_i < left_val_i)) begin
        vld_d = 1'b1;
        val_d = left_val_i;
      end else if (left_vld_i && (!cur_vld || smp_i < val_q)) begin
        vld_d = 1'b1;
        val_d = smp_i;
      end
    end
    if (ctrl_i.shift) begin
      vld_d = right_vld_i;
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= vld_d;
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign vld_o = cur_vld;
  assign val_o = val_q;

endmodule

/* sv/tsfs_divider.sv */
// ---------------------------------------------------------------------------
// tsfs_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsfs_divider #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   quot_q, quot_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DW:0]     trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[NW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = DW'(trial - {1'b0, den_q});
        quot_d = {quot_q[NW-2:0], 1'b1};
      end else begin
        rem_d  = DW'(trial);
        quot_d = {quot_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* sv/touch_sample_filter_and_scale.sv */
// ---------------------------------------------------------------------------
// touch_sample_filter_and_scale
// Trimmed-mean filter and screen scaler for resistive touch samples.
// ---------------------------------------------------------------------------
// Input channel: sample_i, cmd_i (axis), pen_up_i; beat taken on in_valid_i
// and not in_stall_o. Output channel: position_o, axis_o, status_o with
// out_valid_o, held while out_stall_i is high.
// Each sample enters a row of BATCH_SIZE sorting cells as it arrives, one
// beat per cycle while the row fills and no result waits. The last sample
// closes the batch: the row then shifts its values out into an
// accumulator, the filtered value is checked, and a second accepted value
// starts a 24-bit restoring divider unless the calibration span is zero.
// Pen-up beats give a status result in the cycle after the beat. The input
// stalls while a batch is being reduced and while an undelivered result
// sits in the output register.
// Reset empties the row, drops any pending result and loads the registers
// with their defaults.
// Configuration writes go through cfg_we_i / cfg_idx_i / cfg_data_i.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module touch_sample_filter_and_scale #(
  parameter int unsigned BATCH_SIZE = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tsfs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tsfs_pkg::RegW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tsfs_pkg::AdcBits-1:0]  sample_i,
  input  logic                          cmd_i,
  input  logic                          pen_up_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tsfs_pkg::PosW-1:0]     position_o,
  output logic                          axis_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned AdcW  = tsfs_pkg::AdcBits;
  localparam int unsigned Keep  = tsfs_pkg::KeepCount;
  localparam int unsigned CntW  = $clog2(BATCH_SIZE + 1);
  localparam int unsigned SumW  = AdcW + $clog2(Keep + 1);
  localparam int unsigned Skip  = (BATCH_SIZE - Keep) / 2;
  localparam int unsigned KeepW = $clog2(Keep);
  localparam int unsigned RW    = tsfs_pkg::RegW;
  localparam int unsigned NumW  = 2 * RW;

  // configuration
  logic [RW-1:0] cfg_q [8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[tsfs_pkg::REG_X_CAL_LOW]     <= RW'(0);
      cfg_q[tsfs_pkg::REG_X_CAL_HIGH]    <= RW'(4095);
      cfg_q[tsfs_pkg::REG_Y_CAL_LOW]     <= RW'(0);
      cfg_q[tsfs_pkg::REG_Y_CAL_HIGH]    <= RW'(4095);
      cfg_q[tsfs_pkg::REG_SCREEN_WIDTH]  <= RW'(240);
      cfg_q[tsfs_pkg::REG_SCREEN_HEIGHT] <= RW'(320);
      cfg_q[tsfs_pkg::REG_MIN_LEVEL]     <= RW'(50);
      cfg_q[tsfs_pkg::REG_MAX_SPREAD]    <= RW'(50);
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // state
  tsfs_pkg::fsm_e state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     step_q, step_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [AdcW-1:0]     first_q, first_d;
  logic                have_q, have_d;
  logic                axis_q, axis_d;
  logic                ovld_q, ovld_d;
  logic [RW-1:0]       pos_q, pos_d;
  logic                oaxis_q, oaxis_d;
  logic [1:0]          stat_q, stat_d;
  logic [RW-1:0]       size_q, size_d;
  logic [RW:0]         mdiff_q, mdiff_d;
  logic                neg_q, neg_d;

  tsfs_pkg::row_ctrl_t ctrl;
  logic                in_acc;
  logic                div_start;
  logic [NumW-1:0]     div_num;
  logic [RW-1:0]       div_den;
  logic                div_done;
  logic [NumW-1:0]     div_quot;

  assign in_stall_o = (state_q != tsfs_pkg::FSM_IDLE) || ovld_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  // sorting row; entry 0 is the left end, the last entry the right end
  logic                c_vld [BATCH_SIZE+2];
  logic [AdcW-1:0]     c_val [BATCH_SIZE+2];

  logic load_sample;
  assign load_sample = in_acc && !pen_up_i;
  assign c_vld[0]            = 1'b1;
  assign c_val[0]            = '0;
  assign c_vld[BATCH_SIZE+1] = 1'b0;
  assign c_val[BATCH_SIZE+1] = '0;

  for (genvar g = 0; g < BATCH_SIZE; g++) begin : g_row
    tsfs_sort_cell #(.W(AdcW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .smp_i       (sample_i),
      .left_vld_i  (c_vld[g]),
      .left_val_i  (c_val[g]),
      .right_vld_i (c_vld[g+2]),
      .right_val_i (c_val[g+2]),
      .vld_o       (c_vld[g+1]),
      .val_o       (c_val[g+1])
    );
  end

  // axis-dependent calibration
  logic [RW-1:0] cal_lo, cal_hi, cal_size;
  always_comb begin
    if (axis_q) begin
      cal_lo   = cfg_q[tsfs_pkg::REG_Y_CAL_LOW];
      cal_hi   = cfg_q[tsfs_pkg::REG_Y_CAL_HIGH];
      cal_size = cfg_q[tsfs_pkg::REG_SCREEN_HEIGHT];
    end else begin
      cal_lo   = cfg_q[tsfs_pkg::REG_X_CAL_LOW];
      cal_hi   = cfg_q[tsfs_pkg::REG_X_CAL_HIGH];
      cal_size = cfg_q[tsfs_pkg::REG_SCREEN_WIDTH];
    end
  end

  logic [AdcW-1:0]     filt;
  logic [AdcW-1:0]     spread;
  logic [AdcW:0]       msum;
  logic [RW-1:0]       mean;
  logic [RW:0]         mdiff;
  logic [RW:0]         ddiff;
  logic                dneg;
  logic [RW-1:0]       dmag;

  assign filt   = AdcW'(sum_q >> KeepW);
  assign spread = (filt > first_q) ? filt - first_q : first_q - filt;
  assign msum   = {1'b0, filt} + {1'b0, first_q};
  assign mean   = RW'(msum >> 1);
  assign mdiff  = {1'b0, mean} - {1'b0, cal_lo};
  assign ddiff  = {1'b0, cal_hi} - {1'b0, cal_lo};
  assign dneg   = ddiff[RW];
  assign dmag   = dneg ? RW'(-ddiff) : ddiff[RW-1:0];

  // numerator magnitude: size * |mean - low|
  logic [RW-1:0] nmag;
  assign nmag    = mdiff_q[RW] ? RW'(-mdiff_q) : mdiff_q[RW-1:0];
  assign div_num = NumW'(size_q) * NumW'(nmag);
  assign div_den = dmag;

  tsfs_divider #(.NW(NumW), .DW(RW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsfs_pkg::FSM_IDLE: begin
        if (load_sample && (cnt_d == CntW'(BATCH_SIZE))) state_d = tsfs_pkg::FSM_SORT;
      end
      tsfs_pkg::FSM_SORT:  state_d = tsfs_pkg::FSM_SUM;
      tsfs_pkg::FSM_SUM: begin
        if (step_q == CntW'(BATCH_SIZE - 1)) state_d = tsfs_pkg::FSM_CHECK;
      end
      tsfs_pkg::FSM_CHECK: begin
        if (filt < cfg_q[tsfs_pkg::REG_MIN_LEVEL] || !have_q ||
            spread > cfg_q[tsfs_pkg::REG_MAX_SPREAD] || ddiff == '0) begin
          state_d = tsfs_pkg::FSM_IDLE;
        end else begin
          state_d = tsfs_pkg::FSM_DIV;
        end
      end
      tsfs_pkg::FSM_DIV:   state_d = tsfs_pkg::FSM_OUT;
      tsfs_pkg::FSM_OUT: begin
        if (div_done) state_d = tsfs_pkg::FSM_IDLE;
      end
      default: state_d = tsfs_pkg::FSM_IDLE;
    endcase
  end

  // datapath and outputs
  logic axis_chg;
  assign axis_chg = (cmd_i != axis_q);

  always_comb begin
    ctrl      = '0;
    cnt_d     = cnt_q;
    step_d    = step_q;
    sum_d     = sum_q;
    first_d   = first_q;
    have_d    = have_q;
    axis_d    = axis_q;
    ovld_d    = ovld_q && out_stall_i;
    pos_d     = pos_q;
    oaxis_d   = oaxis_q;
    stat_d    = stat_q;
    size_d    = size_q;
    mdiff_d   = mdiff_q;
    neg_d     = neg_q;
    div_start = 1'b0;
    case (state_q)
      tsfs_pkg::FSM_IDLE: begin
        if (in_acc && pen_up_i) begin
          cnt_d      = '0;
          have_d     = 1'b0;
          ctrl.clear = 1'b1;
          ovld_d     = 1'b1;
          pos_d      = '0;
          oaxis_d    = cmd_i;
          stat_d     = tsfs_pkg::ST_PEN_UP;
        end else if (load_sample) begin
          if (axis_chg) begin
            have_d = 1'b0;
            axis_d = cmd_i;
          end
          cnt_d = CntW'(1) + ((axis_chg) ? '0 : cnt_q);
        end
      end
      tsfs_pkg::FSM_SORT: begin
        cnt_d  = '0;
        step_d = '0;
        sum_d  = '0;
      end
      tsfs_pkg::FSM_SUM: begin
        ctrl.shift = 1'b1;
        if (step_q >= CntW'(Skip) && step_q < CntW'(Skip + Keep)) begin
          sum_d = sum_q + SumW'(c_val[1]);
        end
        step_d = step_q + 1'b1;
      end
      tsfs_pkg::FSM_CHECK: begin
        ctrl.clear = 1'b1;
        if (filt < cfg_q[tsfs_pkg::REG_MIN_LEVEL]) begin
          have_d = 1'b0;
        end else if (!have_q) begin
          first_d = filt;
          have_d  = 1'b1;
        end else begin
          have_d = 1'b0;
          if (spread <= cfg_q[tsfs_pkg::REG_MAX_SPREAD]) begin
            oaxis_d = axis_q;
            if (ddiff == '0) begin
              ovld_d = 1'b1;
              pos_d  = '0;
              stat_d = tsfs_pkg::ST_CAL_ZERO;
            end else begin
              size_d  = cal_size;
              mdiff_d = mdiff;
              neg_d   = mdiff[RW] ^ dneg;
            end
          end
        end
      end
      tsfs_pkg::FSM_DIV: begin
        div_start = 1'b1;
      end
      tsfs_pkg::FSM_OUT: begin
        if (div_done) begin
          ovld_d = 1'b1;
          stat_d = tsfs_pkg::ST_VALID;
          if (size_q == '0 || (neg_q && div_quot != '0)) begin
            pos_d = '0;
          end else if (div_quot > NumW'(size_q - 1'b1)) begin
            pos_d = size_q - 1'b1;
          end else begin
            pos_d = RW'(div_quot);
          end
        end
      end
      default: ;
    endcase
    ctrl.load = load_sample;
    // cells see the clear of a pen-up, an axis change or a new batch too
    if (load_sample && axis_chg) ctrl.clear = 1'b1;
    if (load_sample && !axis_chg && cnt_q == '0) ctrl.clear = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsfs_pkg::FSM_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      have_q  <= 1'b0;
      axis_q  <= 1'b0;
      ovld_q  <= 1'b0;
      first_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      have_q  <= have_d;
      axis_q  <= axis_d;
      ovld_q  <= ovld_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    pos_q   <= pos_d;
    oaxis_q <= oaxis_d;
    stat_q  <= stat_d;
    size_q  <= size_d;
    mdiff_q <= mdiff_d;
    neg_q   <= neg_d;
  end

  assign out_valid_o = ovld_q;
  assign position_o  = pos_q;
  assign axis_o      = oaxis_q;
  assign status_o    = stat_q;

endmodule

/* sv/tsfs_checker.sv */
// ---------------------------------------------------------------------------
// tsfs_checker
// Port-level checks of the touch sample filter and scaler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsfs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       pen_up_i,
  input logic       cmd_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic       axis_o,
  input logic [11:0] position_o
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(position_o))
  `ASSERT_IMPL(a_status_code, clk_i, rst_ni, out_valid_o,
               status_o <= tsfs_pkg::ST_CAL_ZERO)
  `ASSERT_IMPL(a_nonvalid_zero, clk_i, rst_ni, out_valid_o && status_o != tsfs_pkg::ST_VALID,
               position_o == '0)
  `ASSERT_NEXT(a_pen_result, clk_i, rst_ni, in_valid_i && !in_stall_o && pen_up_i,
               out_valid_o && status_o == tsfs_pkg::ST_PEN_UP && axis_o == $past(cmd_i))
  `ASSERT_IMPL(a_stall_full, clk_i, rst_ni, out_valid_o, in_stall_o)

endmodule

bind touch_sample_filter_and_scale tsfs_checker u_tsfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .pen_up_i    (pen_up_i),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .axis_o      (axis_o),
  .position_o  (position_o)
);

/* verif/tb_touch_sample_filter_and_scale.sv */
// ---------------------------------------------------------------------------
// tb_touch_sample_filter_and_scale
// Self-checking bench for the touch sample trimmed-mean filter and scaler.
// Drives sample beats and register writes, predicts every result beat, and
// compares each delivered beat field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_touch_sample_filter_and_scale;

  localparam int unsigned Batch = 10;
  localparam int unsigned Keep  = 4;
  localparam int unsigned Drain = 80;

  typedef struct packed {
    logic [11:0]       position;
    logic              axis;
    tsfs_pkg::status_e status;
  } touch_result_t;

  typedef struct {
    logic [11:0]   sample;
    logic          cmd;
    logic          pen_up;
    logic          fixed;
    touch_result_t want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  tsfs_pkg::reg_idx_e cfg_idx_i = tsfs_pkg::REG_X_CAL_LOW;
  logic [11:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [11:0]        sample_i = '0;
  logic               cmd_i = 1'b0;
  logic               pen_up_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [11:0]        position_o;
  logic               axis_o;
  logic [1:0]         status_o;

  touch_sample_filter_and_scale dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .sample_i, .cmd_i, .pen_up_i,
    .out_valid_o, .out_stall_i, .position_o, .axis_o, .status_o
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [11:0] cal_regs [8];
  logic [11:0] batch_buf [Batch];
  int unsigned fill_cnt;
  logic [11:0] first_val;
  logic        first_ok;
  logic        cur_axis;

  touch_result_t pending_results [$];
  touch_result_t fixed_results [$];
  int unsigned   mismatches = 0;
  logic          quiet = 1'b0;
  logic          hold_long = 1'b0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  function automatic logic [11:0] trimmed_mean();
    logic [11:0] s [Batch];
    logic [11:0] t;
    int unsigned sum;
    for (int i = 0; i < Batch; i++) s[i] = batch_buf[i];
    for (int i = 0; i < Batch; i++)
      for (int j = 0; j < Batch - 1 - i; j++)
        if (s[j] > s[j+1]) begin
          t = s[j]; s[j] = s[j+1]; s[j+1] = t;
        end
    sum = 0;
    for (int i = 0; i < Keep; i++) sum += s[(Batch - Keep) / 2 + i];
    return 12'(sum / Keep);
  endfunction

  function automatic void predict_position(input logic [11:0] smp, input logic ax,
                                           input logic pen);
    touch_result_t r;
    logic [11:0] f, lo, hi, sz, mean, d;
    int signed num, den, q;
    if (pen) begin
      fill_cnt = 0; first_ok = 1'b0;
      r.position = '0; r.axis = ax; r.status = tsfs_pkg::ST_PEN_UP;
      pending_results.push_back(r);
      return;
    end
    if (ax != cur_axis) begin
      fill_cnt = 0; first_ok = 1'b0; cur_axis = ax;
    end
    batch_buf[fill_cnt] = smp;
    fill_cnt++;
    if (fill_cnt < Batch) return;
    fill_cnt = 0;
    f = trimmed_mean();
    if (f < cal_regs[tsfs_pkg::REG_MIN_LEVEL]) begin
      first_ok = 1'b0;
      return;
    end
    if (!first_ok) begin
      first_val = f; first_ok = 1'b1;
      return;
    end
    first_ok = 1'b0;
    d = (f > first_val) ? f - first_val : first_val - f;
    if (d > cal_regs[tsfs_pkg::REG_MAX_SPREAD]) return;
    mean = 12'((13'(f) + 13'(first_val)) / 2);
    lo = cur_axis ? cal_regs[tsfs_pkg::REG_Y_CAL_LOW] : cal_regs[tsfs_pkg::REG_X_CAL_LOW];
    hi = cur_axis ? cal_regs[tsfs_pkg::REG_Y_CAL_HIGH] : cal_regs[tsfs_pkg::REG_X_CAL_HIGH];
    sz = cur_axis ? cal_regs[tsfs_pkg::REG_SCREEN_HEIGHT]
                  : cal_regs[tsfs_pkg::REG_SCREEN_WIDTH];
    r.axis = cur_axis;
    if (lo == hi) begin
      r.position = '0; r.status = tsfs_pkg::ST_CAL_ZERO;
    end else begin
      num = int'(sz) * (int'(mean) - int'(lo));
      den = int'(hi) - int'(lo);
      q = num / den;
      if (sz == 0 || q < 0) q = 0;
      else if (q > int'(sz) - 1) q = int'(sz) - 1;
      r.position = 12'(q); r.status = tsfs_pkg::ST_VALID;
    end
    pending_results.push_back(r);
  endfunction

  task automatic write_reg(input tsfs_pkg::reg_idx_e idx, input logic [11:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cal_regs[idx] = val;
  endtask

  task automatic settle();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (Drain) @(negedge clk_i);
  endtask

  task automatic send_beat(input logic [11:0] smp, input logic ax, input logic pen);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1; sample_i <= smp; cmd_i <= ax; pen_up_i <= pen;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_position(smp, ax, pen);
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // send a pair of batches near a level, with spread jitter
  task automatic send_touch(input logic ax, input int unsigned lvl, input int unsigned jit);
    int unsigned v;
    for (int b = 0; b < 2 * Batch; b++) begin
      v = lvl + $urandom_range(0, jit);
      if (v > 4095) v = 4095;
      if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 4095);
      send_beat(12'(v), ax, 1'b0);
    end
  endtask

  always @(posedge clk_i) begin
    touch_result_t got, exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.position = position_o; got.axis = axis_o;
      got.status = tsfs_pkg::status_e'(status_o);
      if (pending_results.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        exp = pending_results.pop_front();
        if (fixed_results.size() != 0) begin
          if (fixed_results[0] != exp) report("table row disagrees with prediction");
          void'(fixed_results.pop_front());
        end
        if (got.position !== exp.position)
          report($sformatf("position %0d want %0d", got.position, exp.position));
        if (got.axis !== exp.axis)
          report($sformatf("axis %0d want %0d", got.axis, exp.axis));
        if (got.status !== exp.status)
          report($sformatf("status %0d want %0d", got.status, exp.status));
      end
    end
  end

  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        hold = 0;
        while (hold < 300) begin
          @(negedge clk_i);
          hold++;
        end
        out_stall_i <= 1'b0;
        wait (!hold_long);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    int unsigned lvl;
    cal_regs[tsfs_pkg::REG_X_CAL_LOW] = 0;
    cal_regs[tsfs_pkg::REG_X_CAL_HIGH] = 4095;
    cal_regs[tsfs_pkg::REG_Y_CAL_LOW] = 0;
    cal_regs[tsfs_pkg::REG_Y_CAL_HIGH] = 4095;
    cal_regs[tsfs_pkg::REG_SCREEN_WIDTH] = 240;
    cal_regs[tsfs_pkg::REG_SCREEN_HEIGHT] = 320;
    cal_regs[tsfs_pkg::REG_MIN_LEVEL] = 50;
    cal_regs[tsfs_pkg::REG_MAX_SPREAD] = 50;
    fill_cnt = 0; first_val = '0; first_ok = 1'b0; cur_axis = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table: pen-up rows and the last full-scale row carry a typed result
    row = '{12'hFFF, 1'b0, 1'b1, 1'b1, '{12'd0, 1'b0, tsfs_pkg::ST_PEN_UP}};
    rows.push_back(row);
    row = '{12'h000, 1'b1, 1'b1, 1'b1, '{12'd0, 1'b1, tsfs_pkg::ST_PEN_UP}};
    rows.push_back(row);
    for (int i = 0; i < 20; i++) begin
      row = '{12'hFFF, 1'b0, 1'b0, 1'b0, '{12'd0, 1'b0, tsfs_pkg::ST_VALID}};
      if (i == 19) row = '{12'hFFF, 1'b0, 1'b0, 1'b1, '{12'd239, 1'b0, tsfs_pkg::ST_VALID}};
      rows.push_back(row);
    end
    row = '{12'hABC, 1'b1, 1'b1, 1'b1, '{12'd0, 1'b1, tsfs_pkg::ST_PEN_UP}};
    rows.push_back(row);
    foreach (rows[i]) begin
      if (rows[i].fixed) fixed_results.push_back(rows[i].want);
      send_beat(rows[i].sample, rows[i].cmd, rows[i].pen_up);
    end
    // low level rejected with zeros, axis change mid batch, then a touch near 2000
    for (int i = 0; i < 20; i++) send_beat(12'd0, 1'b1, 1'b0);
    for (int i = 0; i < 5; i++) send_beat(12'd1000, 1'b0, 1'b0);
    send_touch(1'b1, 2000, 0);
    idle_input();
    settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(tsfs_pkg::REG_X_CAL_LOW, 12'd0);
          write_reg(tsfs_pkg::REG_X_CAL_HIGH, 12'd0);
          write_reg(tsfs_pkg::REG_Y_CAL_LOW, 12'd4095);
          write_reg(tsfs_pkg::REG_Y_CAL_HIGH, 12'd0);
          write_reg(tsfs_pkg::REG_SCREEN_WIDTH, 12'd1);
          write_reg(tsfs_pkg::REG_SCREEN_HEIGHT, 12'd4095);
          write_reg(tsfs_pkg::REG_MIN_LEVEL, 12'd0);
          write_reg(tsfs_pkg::REG_MAX_SPREAD, 12'd4095);
        end
        1: begin
          write_reg(tsfs_pkg::REG_X_CAL_LOW, 12'd300);
          write_reg(tsfs_pkg::REG_X_CAL_HIGH, 12'd3800);
          write_reg(tsfs_pkg::REG_Y_CAL_LOW, 12'd3700);
          write_reg(tsfs_pkg::REG_Y_CAL_HIGH, 12'd250);
          write_reg(tsfs_pkg::REG_SCREEN_WIDTH, 12'd240);
          write_reg(tsfs_pkg::REG_SCREEN_HEIGHT, 12'd320);
          write_reg(tsfs_pkg::REG_MIN_LEVEL, 12'd50);
          write_reg(tsfs_pkg::REG_MAX_SPREAD, 12'd0);
        end
        2: begin
          write_reg(tsfs_pkg::REG_Y_CAL_LOW, 12'd1234);
          write_reg(tsfs_pkg::REG_Y_CAL_HIGH, 12'd1234);
          write_reg(tsfs_pkg::REG_SCREEN_WIDTH, 12'd4095);
          write_reg(tsfs_pkg::REG_MIN_LEVEL, 12'd4095);
          write_reg(tsfs_pkg::REG_MAX_SPREAD, 12'd30);
        end
        3: begin
          write_reg(tsfs_pkg::REG_X_CAL_LOW, 12'd4095);
          write_reg(tsfs_pkg::REG_X_CAL_HIGH, 12'd1);
          write_reg(tsfs_pkg::REG_Y_CAL_LOW, 12'd100);
          write_reg(tsfs_pkg::REG_Y_CAL_HIGH, 12'd4000);
          write_reg(tsfs_pkg::REG_MIN_LEVEL, 12'd200);
          write_reg(tsfs_pkg::REG_MAX_SPREAD, 12'd100);
        end
        4: hold_long = 1'b1;
        default: quiet = 1'b1;
      endcase
      for (int t = 0; t < 11; t++) begin
        lvl = $urandom_range(0, 4095);
        case ($urandom_range(0, 5))
          0: send_beat(12'($urandom), 1'($urandom), 1'b1);
          1: for (int k = 0; k < 7; k++) send_beat(12'($urandom), 1'($urandom), 1'b0);
          default: send_touch(1'($urandom), lvl, $urandom_range(0, 80));
        endcase
      end
      hold_long = 1'b0;
      idle_input();
      settle();
    end

    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
